>>> rtl/core/tcsi_pkg.sv
// ----------------------------------------------------------------------------
// tcsi_pkg
// Shared types and constants for the sorted-intersection triangle counter.
// ----------------------------------------------------------------------------
package tcsi_pkg;

    localparam int REQ_W = 2;
    localparam int IDX_W = 13;
    localparam int VAL_W = 14;
    localparam int VTX_W = 10;
    localparam int NBR_W = 10;
    localparam int CNT_W = 10;
    localparam int TOT_W = 32;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [REQ_W-1:0] REQ_WR_OFF = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WR_ADJ = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EDGE   = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_OFF1,
        S_OFF2,
        S_MERGE
    } t_eng_state;

    typedef struct packed {
        logic             off_en;
        logic             adj_en;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
    } t_wr;

    typedef struct packed {
        logic start;
        logic take;
    } t_eng_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_sts;

endpackage

>>> rtl/core/tcsi_ram.sv
// ----------------------------------------------------------------------------
// tcsi_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tcsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/tcsi_engine.sv
// ----------------------------------------------------------------------------
// tcsi_engine
// CSR tables and merge sequencer: fetches both offset pairs, then walks the
// two sorted neighbour lists one compare per cycle and counts common ids.
// ----------------------------------------------------------------------------
module tcsi_engine
    import tcsi_pkg::*;
#(
    parameter int MAX_VERTICES    = 1024,
    parameter int MAX_ADJ_ENTRIES = 8192,
    localparam int PW             = $clog2(MAX_ADJ_ENTRIES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_wr              i_wr,
    input  t_eng_ctl         i_ctl,
    input  logic [VTX_W-1:0] i_va,
    input  logic [VTX_W-1:0] i_vb,
    output t_eng_sts         o_sts,
    output logic [PW-1:0]    o_hits
);

    localparam int OAW = $clog2(MAX_VERTICES + 1);
    localparam int NAW = $clog2(MAX_ADJ_ENTRIES);

    function automatic logic [PW-1:0] clamp_off(input logic [VAL_W-1:0] off);
        logic [PW-1:0] res;
        if (32'(off) > 32'(MAX_ADJ_ENTRIES)) begin
            res = PW'(MAX_ADJ_ENTRIES);
        end else begin
            res = PW'(off);
        end
        return res;
    endfunction

    t_eng_state r_state, n_state;

    logic [VTX_W-1:0] r_va, n_va;
    logic [VTX_W-1:0] r_vb, n_vb;
    logic [PW-1:0]    r_ia, n_ia;
    logic [PW-1:0]    r_ib, n_ib;
    logic [PW-1:0]    r_ea, n_ea;
    logic [PW-1:0]    r_eb, n_eb;
    logic [PW-1:0]    r_hits, n_hits;
    logic             r_empty, n_empty;

    logic [OAW-1:0]   off_raddr_a, off_raddr_b;
    logic [VAL_W-1:0] off_rdata_a, off_rdata_b;
    logic [NBR_W-1:0] nbr_rdata_a, nbr_rdata_b;
    logic [PW-1:0]    end_a, end_b;
    logic             run;
    logic             done;

    tcsi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_VERTICES + 1)) u_off_a (
        .i_clk   (i_clk),
        .i_we    (i_wr.off_en),
        .i_waddr (OAW'(i_wr.idx)),
        .i_wdata (i_wr.val),
        .i_raddr (off_raddr_a),
        .o_rdata (off_rdata_a)
    );

    tcsi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_VERTICES + 1)) u_off_b (
        .i_clk   (i_clk),
        .i_we    (i_wr.off_en),
        .i_waddr (OAW'(i_wr.idx)),
        .i_wdata (i_wr.val),
        .i_raddr (off_raddr_b),
        .o_rdata (off_rdata_b)
    );

    tcsi_ram #(.WIDTH(NBR_W), .DEPTH(MAX_ADJ_ENTRIES)) u_nbr_a (
        .i_clk   (i_clk),
        .i_we    (i_wr.adj_en),
        .i_waddr (NAW'(i_wr.idx)),
        .i_wdata (i_wr.val[NBR_W-1:0]),
        .i_raddr (NAW'(n_ia)),
        .o_rdata (nbr_rdata_a)
    );

    tcsi_ram #(.WIDTH(NBR_W), .DEPTH(MAX_ADJ_ENTRIES)) u_nbr_b (
        .i_clk   (i_clk),
        .i_we    (i_wr.adj_en),
        .i_waddr (NAW'(i_wr.idx)),
        .i_wdata (i_wr.val[NBR_W-1:0]),
        .i_raddr (NAW'(n_ib)),
        .o_rdata (nbr_rdata_b)
    );

    assign end_a = clamp_off(off_rdata_a);
    assign end_b = clamp_off(off_rdata_b);
    assign run   = !r_empty && (r_ia < r_ea) && (r_ib < r_eb);
    assign done  = (r_state == S_MERGE) && !run;

    always_comb begin
        n_state     = r_state;
        n_va        = r_va;
        n_vb        = r_vb;
        n_ia        = r_ia;
        n_ib        = r_ib;
        n_ea        = r_ea;
        n_eb        = r_eb;
        n_hits      = r_hits;
        n_empty     = r_empty;
        off_raddr_a = OAW'({1'b0, r_va} + (VTX_W + 1)'(1));
        off_raddr_b = OAW'({1'b0, r_vb} + (VTX_W + 1)'(1));
        case (r_state)
            S_IDLE: begin
                off_raddr_a = OAW'(i_va);
                off_raddr_b = OAW'(i_vb);
                if (i_ctl.start) begin
                    n_va    = i_va;
                    n_vb    = i_vb;
                    n_hits  = '0;
                    n_state = S_OFF1;
                end
            end
            S_OFF1: begin
                n_ia    = clamp_off(off_rdata_a);
                n_ib    = clamp_off(off_rdata_b);
                n_state = S_OFF2;
            end
            S_OFF2: begin
                n_ea    = end_a;
                n_eb    = end_b;
                n_empty = (32'(r_va) >= 32'(MAX_VERTICES))
                       || (32'(r_vb) >= 32'(MAX_VERTICES))
                       || (end_a <= r_ia) || (end_b <= r_ib);
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (run) begin
                    if (nbr_rdata_a < nbr_rdata_b) begin
                        n_ia = r_ia + PW'(1);
                    end else if (nbr_rdata_a > nbr_rdata_b) begin
                        n_ib = r_ib + PW'(1);
                    end else begin
                        n_ia   = r_ia + PW'(1);
                        n_ib   = r_ib + PW'(1);
                        n_hits = r_hits + PW'(1);
                    end
                end else if (i_ctl.take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_va    <= n_va;
        r_vb    <= n_vb;
        r_ia    <= n_ia;
        r_ib    <= n_ib;
        r_ea    <= n_ea;
        r_eb    <= n_eb;
        r_hits  <= n_hits;
        r_empty <= n_empty;
    end

    assign o_sts.busy = (r_state != S_IDLE);
    assign o_sts.done = done;
    assign o_hits     = r_hits;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> (r_state == S_IDLE))
        else $error("edge start while engine busy");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE && !r_empty) |-> (r_ia <= r_ea && r_ib <= r_eb))
        else $error("merge pointer past list end");

    a_merge_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> ($past(r_state) == S_OFF2 || $past(r_state) == S_MERGE))
        else $error("merge entered without offset fetch");

endmodule

>>> rtl/core/triangle_count_sorted_intersection.sv
// ----------------------------------------------------------------------------
// triangle_count_sorted_intersection
// CSR graph store with merge-based common-neighbour count per edge and a
// saturating running total per chunk.
// ----------------------------------------------------------------------------
// Writes give no result and run back to back at one per cycle while o_stall is low.
// An edge passes from transfer through S_OFF1, S_OFF2 and the merge compares (at
// most len(a) + len(b)) into the result register; o_stall stays high until it is
// loaded, and a stalled result holds the sequencer in its last state.
// Reset clears the sequencer, the output valid flag and the running total; the
// offset and neighbour tables hold no defined value until written.
// ----------------------------------------------------------------------------
module triangle_count_sorted_intersection
    import tcsi_pkg::*;
#(
    parameter int MAX_VERTICES    = 1024,
    parameter int MAX_ADJ_ENTRIES = 8192
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [REQ_W-1:0] i_req_type,
    input  logic [IDX_W-1:0] i_write_index,
    input  logic [VAL_W-1:0] i_write_value,
    input  logic [VTX_W-1:0] i_vertex_a,
    input  logic [VTX_W-1:0] i_vertex_b,
    input  logic             i_last_in_chunk,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [CNT_W-1:0] o_common_count,
    output logic [TOT_W-1:0] o_chunk_total,
    output logic             o_chunk_done
);

    localparam int PW = $clog2(MAX_ADJ_ENTRIES + 1);

    t_wr           wr;
    t_eng_ctl      eng_ctl;
    t_eng_sts      eng_sts;
    logic [PW-1:0] hits;
    logic          accept;
    logic          load;
    logic [TOT_W:0]   sum;
    logic [TOT_W-1:0] sat;

    logic             r_out_valid;
    logic [TOT_W-1:0] r_total;
    logic             r_last;
    logic [CNT_W-1:0] r_common;
    logic [TOT_W-1:0] r_chunk_total;
    logic             r_chunk_done;

    assign o_stall = eng_sts.busy;
    assign accept  = i_valid && !o_stall;

    assign wr.off_en = accept && (i_req_type == REQ_WR_OFF)
                    && (32'(i_write_index) <= 32'(MAX_VERTICES));
    assign wr.adj_en = accept && (i_req_type == REQ_WR_ADJ)
                    && (32'(i_write_index) < 32'(MAX_ADJ_ENTRIES));
    assign wr.idx    = i_write_index;
    assign wr.val    = i_write_value;

    assign eng_ctl.start = accept && (i_req_type == REQ_EDGE);
    assign eng_ctl.take  = !r_out_valid || !i_stall;

    tcsi_engine #(
        .MAX_VERTICES    (MAX_VERTICES),
        .MAX_ADJ_ENTRIES (MAX_ADJ_ENTRIES)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_ctl   (eng_ctl),
        .i_va    (i_vertex_a),
        .i_vb    (i_vertex_b),
        .o_sts   (eng_sts),
        .o_hits  (hits)
    );

    assign load = eng_sts.done && eng_ctl.take;
    assign sum  = {1'b0, r_total} + (TOT_W + 1)'(hits);
    assign sat  = sum[TOT_W] ? '1 : sum[TOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_total     <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_total     <= r_last ? '0 : sat;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_ctl.start) begin
            r_last <= i_last_in_chunk;
        end
        if (load) begin
            r_common      <= (32'(hits) > 32'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(hits);
            r_chunk_total <= sat;
            r_chunk_done  <= r_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_common_count = r_common;
    assign o_chunk_total  = r_chunk_total;
    assign o_chunk_done   = r_chunk_done;

    a_chunk_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_last) |=> (r_total == '0))
        else $error("running total not cleared after chunk end");

    a_total_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (TOT_W'(r_common) <= r_chunk_total))
        else $error("chunk total below edge count");

endmodule
